// ----- sv/button_edge_release_deglitch_defines.svh -----
// assertion macros shared by the block
`ifndef BUTTON_EDGE_RELEASE_DEGLITCH_DEFINES_SVH
`define BUTTON_EDGE_RELEASE_DEGLITCH_DEFINES_SVH

// clocked check, muted while reset is held
`define BERED_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define BERED_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ----- sv/bered_pkg.sv -----
package bered_pkg;

    localparam int SLOTS     = 32;
    localparam int SLOT_W    = 5;
    localparam int DATA_W    = 32;
    localparam int VAL_W     = 8;
    localparam int BPS_W     = 4;
    localparam int THR_W     = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] NO_DELAY = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BITS_PER_SLOT = 2'd0,
        CFG_DEGLITCH_MASK = 2'd1,
        CFG_CHATTER_THR   = 2'd2
    } t_cfg_idx;

    // decoded configuration, bps already clamped to 1..8
    typedef struct packed {
        logic [BPS_W-1:0]  bps;
        logic [VAL_W-1:0]  mall;
        logic [VAL_W-1:0]  tpress;
        logic [VAL_W-1:0]  trel;
        logic [DATA_W-1:0] mask;
        logic [THR_W-1:0]  thr;
    } t_cfg;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [SLOT_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } t_ram_req;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SLOT  = 7'b0000010,
        S_ELAP  = 7'b0000100,
        S_REM   = 7'b0001000,
        S_CHK   = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_FINAL = 7'b1000000
    } t_state;

endpackage

// ----- sv/button_edge_release_deglitch.sv -----
// channel   dir  handshake             payload
// input     in   i_valid / o_stall     i_raw_buttons, i_now_ms
// result    out  o_valid / i_stall     o_event_valid, o_slot_index, o_is_press,
//                                      o_retry_delay_ms, o_last
// config    in   i_cfg_we              i_cfg_idx, i_cfg_wdata
//
// a request is walked one slot per cycle by the shift/compare sequencer, unless an event holds it
// ceil(32/bits per slot) slots are walked, then final and idle
// a deglitched release steps through two subtracts on the read press time, then a check
// each event result is held in the emit state until the output is no longer stalled
// an unchanged word goes straight to the final result, which also waits out any stall
// synchronous active-low reset; press times read as zero until written

`include "button_edge_release_deglitch_defines.svh"

module button_edge_release_deglitch (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bered_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bered_pkg::DATA_W-1:0]         i_cfg_wdata,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [bered_pkg::DATA_W-1:0]         i_raw_buttons,
    input  logic [bered_pkg::DATA_W-1:0]         i_now_ms,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_event_valid,
    output logic [bered_pkg::SLOT_W-1:0]         o_slot_index,
    output logic                                 o_is_press,
    output logic [bered_pkg::DATA_W-1:0]         o_retry_delay_ms,
    output logic                                 o_last
);

    localparam int VW = bered_pkg::VAL_W;
    localparam int BW = bered_pkg::BPS_W;

    logic [BW-1:0]                 r_bps;
    logic [bered_pkg::DATA_W-1:0]  r_mask;
    logic [bered_pkg::THR_W-1:0]   r_thr;

    logic [BW-1:0]                 bps_c;
    logic [VW-1:0]                 mall;
    logic [VW-1:0]                 tpress;
    bered_pkg::t_cfg               cfg;
    bered_pkg::t_ram_req           ram_req;
    logic [bered_pkg::DATA_W-1:0]  ram_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bps  <= BW'(1);
            r_mask <= '1;
            r_thr  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bered_pkg::CFG_BITS_PER_SLOT: r_bps  <= i_cfg_wdata[BW-1:0];
                bered_pkg::CFG_DEGLITCH_MASK: r_mask <= i_cfg_wdata;
                bered_pkg::CFG_CHATTER_THR:   r_thr  <= i_cfg_wdata[bered_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate slot width to 1..8
    always_comb begin
        if (r_bps == '0) begin
            bps_c = BW'(1);
        end else if (r_bps > BW'(VW)) begin
            bps_c = BW'(VW);
        end else begin
            bps_c = r_bps;
        end
    end

    assign mall   = {VW{1'b1}} >> (BW'(VW) - bps_c);
    assign tpress = mall ^ (mall >> 2);

    always_comb begin
        cfg.bps    = bps_c;
        cfg.mall   = mall;
        cfg.tpress = tpress;
        cfg.trel   = mall - tpress;
        cfg.mask   = r_mask;
        cfg.thr    = r_thr;
    end

    bered_walker u_walker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_raw_buttons    (i_raw_buttons),
        .i_now_ms         (i_now_ms),
        .o_ram_req        (ram_req),
        .i_ram_rd_data    (ram_rd_data),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_event_valid    (o_event_valid),
        .o_slot_index     (o_slot_index),
        .o_is_press       (o_is_press),
        .o_retry_delay_ms (o_retry_delay_ms),
        .o_last           (o_last)
    );

    bered_ptime_ram u_ptime_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ram_req),
        .o_rd_data (ram_rd_data)
    );

    `BERED_ASSERT(a_busy_after_request, i_valid && !o_stall |=> o_stall, "request not held busy")
    `BERED_ASSERT(a_final_is_summary, o_valid && o_last |-> !o_event_valid && !o_is_press, "bad final item")
    `BERED_ASSERT(a_event_no_delay, o_valid && o_event_valid |-> o_retry_delay_ms == '0 && !o_last, "bad event item")
    `BERED_ASSERT(a_idle_after_final, o_valid && o_last && !i_stall |=> !o_valid && !o_stall, "no return to idle")
    `BERED_NEVER(a_ram_single_port, ram_req.wr_en && ram_req.rd_en, "press time read and write together")

endmodule

// ----- sv/bered_ptime_ram.sv -----
module bered_ptime_ram (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bered_pkg::t_ram_req           i_req,
    output logic [bered_pkg::DATA_W-1:0]  o_rd_data
);

    logic [bered_pkg::DATA_W-1:0] r_mem [bered_pkg::SLOTS];
    logic [bered_pkg::SLOTS-1:0]  r_vld;
    logic [bered_pkg::DATA_W-1:0] r_rd_data;

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_vld[i_req.addr] ? r_mem[i_req.addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/bered_walker.sv -----
module bered_walker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bered_pkg::t_cfg                   i_cfg,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [bered_pkg::DATA_W-1:0]      i_raw_buttons,
    input  logic [bered_pkg::DATA_W-1:0]      i_now_ms,
    output bered_pkg::t_ram_req               o_ram_req,
    input  logic [bered_pkg::DATA_W-1:0]      i_ram_rd_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_event_valid,
    output logic [bered_pkg::SLOT_W-1:0]      o_slot_index,
    output logic                              o_is_press,
    output logic [bered_pkg::DATA_W-1:0]      o_retry_delay_ms,
    output logic                              o_last
);

    localparam int DW = bered_pkg::DATA_W;
    localparam int SW = bered_pkg::SLOT_W;
    localparam int VW = bered_pkg::VAL_W;

    bered_pkg::t_state r_state, n_state;

    logic [DW-1:0] r_prev, n_prev;
    logic [DW-1:0] r_sh_raw, n_sh_raw;
    logic [DW-1:0] r_sh_prev, n_sh_prev;
    logic [DW-1:0] r_sh_diff, n_sh_diff;
    logic [DW-1:0] r_fmask, n_fmask;
    logic [DW-1:0] r_now, n_now;
    logic [DW-1:0] r_acc, n_acc;
    logic [DW-1:0] r_delay, n_delay;
    logic [SW-1:0] r_idx, n_idx;
    logic [SW-1:0] r_pos, n_pos;

    logic          r_out_ev, n_out_ev;
    logic [SW-1:0] r_out_slot, n_out_slot;
    logic          r_out_press, n_out_press;
    logic [DW-1:0] r_out_delay, n_out_delay;
    logic          r_out_last, n_out_last;

    logic [VW-1:0] v, pv;
    logic          diff_nz, pressed, released, ppressed, preleased;
    logic          same_class, is_event, in_mask, last_slot, adv, suppress;
    logic [SW:0]   pos_sum;
    logic [DW-1:0] sub_a, sub_b, sub_y;

    assign v         = r_sh_raw[VW-1:0] & i_cfg.mall;
    assign pv        = r_sh_prev[VW-1:0] & i_cfg.mall;
    assign diff_nz   = |(r_sh_diff[VW-1:0] & i_cfg.mall);
    assign pressed   = v >= i_cfg.tpress;
    assign released  = v <= i_cfg.trel;
    assign ppressed  = pv >= i_cfg.tpress;
    assign preleased = pv <= i_cfg.trel;
    // one-bit slots always change class when they change
    assign same_class = (i_cfg.bps != bered_pkg::BPS_W'(1))
                        && (pressed == ppressed) && (released == preleased);
    assign is_event  = diff_nz && (pressed != released) && !same_class;
    assign in_mask   = i_cfg.mask[r_idx];

    assign pos_sum   = {1'b0, r_pos} + (SW+1)'(i_cfg.bps);
    assign last_slot = (r_idx == SW'(bered_pkg::SLOTS - 1)) || pos_sum[SW];

    assign suppress  = (r_acc != '0) && !r_acc[DW-1];

    // shared subtractor: elapsed time, then remaining time
    always_comb begin
        if (r_state == bered_pkg::S_REM) begin
            sub_a = DW'(i_cfg.thr);
            sub_b = r_acc;
        end else begin
            sub_a = r_now;
            sub_b = i_ram_rd_data;
        end
    end
    assign sub_y = sub_a - sub_b;

    always_comb begin
        o_ram_req.wr_en = (r_state == bered_pkg::S_SLOT) && is_event && in_mask && pressed;
        o_ram_req.rd_en = (r_state == bered_pkg::S_SLOT) && is_event && in_mask && !pressed;
        o_ram_req.addr  = r_idx;
        o_ram_req.wdata = r_now;
    end

    always_comb begin
        n_state     = r_state;
        n_prev      = r_prev;
        n_sh_raw    = r_sh_raw;
        n_sh_prev   = r_sh_prev;
        n_sh_diff   = r_sh_diff;
        n_fmask     = r_fmask;
        n_now       = r_now;
        n_acc       = r_acc;
        n_delay     = r_delay;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_out_ev    = r_out_ev;
        n_out_slot  = r_out_slot;
        n_out_press = r_out_press;
        n_out_delay = r_out_delay;
        n_out_last  = r_out_last;
        adv         = 1'b0;

        case (r_state)
            bered_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_now   = i_now_ms;
                    n_delay = bered_pkg::NO_DELAY;
                    if (i_raw_buttons == r_prev) begin
                        n_state     = bered_pkg::S_FINAL;
                        n_out_ev    = 1'b0;
                        n_out_slot  = '0;
                        n_out_press = 1'b0;
                        n_out_delay = bered_pkg::NO_DELAY;
                        n_out_last  = 1'b1;
                    end else begin
                        n_state   = bered_pkg::S_SLOT;
                        n_prev    = i_raw_buttons;
                        n_sh_raw  = i_raw_buttons;
                        n_sh_prev = r_prev;
                        n_sh_diff = i_raw_buttons ^ r_prev;
                        n_fmask   = DW'(i_cfg.mall);
                        n_idx     = '0;
                        n_pos     = '0;
                    end
                end
            end
            bered_pkg::S_SLOT: begin
                if (!is_event) begin
                    adv = 1'b1;
                end else if (in_mask && !pressed) begin
                    n_state = bered_pkg::S_ELAP;
                end else begin
                    n_state     = bered_pkg::S_EMIT;
                    n_out_ev    = 1'b1;
                    n_out_slot  = r_idx;
                    n_out_press = pressed;
                    n_out_delay = '0;
                    n_out_last  = 1'b0;
                end
            end
            bered_pkg::S_ELAP: begin
                n_acc   = sub_y;
                n_state = bered_pkg::S_REM;
            end
            bered_pkg::S_REM: begin
                n_acc   = sub_y;
                n_state = bered_pkg::S_CHK;
            end
            bered_pkg::S_CHK: begin
                if (suppress) begin
                    // short release: hold the slot pressed in the stored word
                    n_prev = r_prev | r_fmask;
                    if (r_delay > r_acc) begin
                        n_delay = r_acc;
                    end
                    adv = 1'b1;
                end else begin
                    n_state     = bered_pkg::S_EMIT;
                    n_out_ev    = 1'b1;
                    n_out_slot  = r_idx;
                    n_out_press = 1'b0;
                    n_out_delay = '0;
                    n_out_last  = 1'b0;
                end
            end
            bered_pkg::S_EMIT: begin
                if (!i_stall) begin
                    adv = 1'b1;
                end
            end
            bered_pkg::S_FINAL: begin
                if (!i_stall) begin
                    n_state = bered_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bered_pkg::S_IDLE;
            end
        endcase

        if (adv) begin
            if (last_slot) begin
                n_state     = bered_pkg::S_FINAL;
                n_out_ev    = 1'b0;
                n_out_slot  = '0;
                n_out_press = 1'b0;
                n_out_delay = n_delay;
                n_out_last  = 1'b1;
            end else begin
                n_state   = bered_pkg::S_SLOT;
                n_sh_raw  = r_sh_raw >> i_cfg.bps;
                n_sh_prev = r_sh_prev >> i_cfg.bps;
                n_sh_diff = r_sh_diff >> i_cfg.bps;
                n_fmask   = r_fmask << i_cfg.bps;
                n_idx     = r_idx + SW'(1);
                n_pos     = pos_sum[SW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bered_pkg::S_IDLE;
            r_prev  <= '0;
        end else begin
            r_state <= n_state;
            r_prev  <= n_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh_raw    <= n_sh_raw;
        r_sh_prev   <= n_sh_prev;
        r_sh_diff   <= n_sh_diff;
        r_fmask     <= n_fmask;
        r_now       <= n_now;
        r_acc       <= n_acc;
        r_delay     <= n_delay;
        r_idx       <= n_idx;
        r_pos       <= n_pos;
        r_out_ev    <= n_out_ev;
        r_out_slot  <= n_out_slot;
        r_out_press <= n_out_press;
        r_out_delay <= n_out_delay;
        r_out_last  <= n_out_last;
    end

    assign o_stall          = (r_state != bered_pkg::S_IDLE);
    assign o_valid          = (r_state == bered_pkg::S_EMIT) || (r_state == bered_pkg::S_FINAL);
    assign o_event_valid    = r_out_ev;
    assign o_slot_index     = r_out_slot;
    assign o_is_press       = r_out_press;
    assign o_retry_delay_ms = r_out_delay;
    assign o_last           = r_out_last;

endmodule
